>>> design/tea_pkg.sv
package tea_pkg;

    localparam int unsigned MaxTrianglesDefault = 1024;
    localparam int unsigned VertexBitsDefault   = 16;
    localparam int unsigned VertexWidth         = 16;
    localparam int unsigned OutTriWidth         = 10;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } action_t;

endpackage

>>> design/tea_if.sv
interface tea_req_if;
    import tea_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [VertexWidth-1:0] vertex_first;
    logic [VertexWidth-1:0] vertex_second;
    logic [VertexWidth-1:0] vertex_third;
    logic                   last_triangle;

    modport source (output valid, action, vertex_first, vertex_second, vertex_third,
                    last_triangle, input ready);
    modport sink   (input valid, action, vertex_first, vertex_second, vertex_third,
                    last_triangle, output ready);
endinterface

interface tea_rsp_if;
    import tea_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OutTriWidth-1:0] later_triangle;
    logic [OutTriWidth-1:0] earlier_triangle;
    logic                   pair_valid;
    logic                   all_done;
    logic                   overflowed;

    modport source (output valid, later_triangle, earlier_triangle, pair_valid, all_done,
                    overflowed, input ready);
    modport sink   (input valid, later_triangle, earlier_triangle, pair_valid, all_done,
                    overflowed, output ready);
endinterface

>>> design/triangle_edge_adjacency.sv
// Channel | Dir | Contents
// req     | in  | action, three vertex indices, last_triangle
// rsp     | out | later/earlier triangle, pair_valid, all_done, overflowed
//
// A stored load runs from the accepting cycle through three writes into the edge memory
// and a closing state before the next request is taken; a dropped load skips the writes.
// The final load starts a bottom-up merge sort through a ping-pong pair of edge
// memories. Every edge of a pass is read, captured, then compared and written,
// with one pass per doubling of the run width until a single run covers all edges.
// Once sorted, a fetch compares neighbouring edges in turn until a pair or the end.
// Reset clears the control state only; the edge memories need no clearing.
// A request is taken only while the block is idle; a stalled response holds.
module triangle_edge_adjacency #(
    parameter int unsigned MAX_TRIANGLES = tea_pkg::MaxTrianglesDefault,
    parameter int unsigned VERTEX_BITS   = tea_pkg::VertexBitsDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    tea_req_if.sink    req,
    tea_rsp_if.source  rsp
);
    import tea_pkg::*;

    localparam int unsigned EdgeCap = 3 * MAX_TRIANGLES;
    localparam int unsigned AW      = $clog2(EdgeCap + 1);
    localparam int unsigned TW      = $clog2(MAX_TRIANGLES + 1);
    localparam int unsigned IW      = $clog2(EdgeCap);
    localparam int unsigned EW      = 2 * VERTEX_BITS + TW;

    typedef logic [EW-1:0] edge_t;

    typedef enum logic [8:0]
    {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_PASS  = 9'b000000100,
        ST_MRDA  = 9'b000001000,
        ST_MRDB  = 9'b000010000,
        ST_MCMP  = 9'b000100000,
        ST_SCANR = 9'b001000000,
        ST_SCANC = 9'b010000000,
        ST_RESP  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    edge_t           mem_a [EdgeCap];
    edge_t           mem_b [EdgeCap];
    edge_t           rd_a_reg, rd_b_reg;
    logic            sel_reg, sel_next;          // 1: data currently lives in mem_b
    logic [TW-1:0]   tri_cnt_reg, tri_cnt_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic            sorted_reg, sorted_next;
    logic            ovf_reg, ovf_next;
    logic [1:0]      ld_idx_reg, ld_idx_next;
    logic            ld_last_reg, ld_last_next;
    logic [VERTEX_BITS-1:0] v0_reg, v1_reg, v2_reg;
    logic [AW:0]     width_reg, width_next;
    logic [AW:0]     i_reg, i_next, j_reg, j_next, mid_reg, mid_next, rgt_reg, rgt_next;
    logic [AW:0]     k_reg, k_next;
    edge_t           ea_reg, ea_next, eb_reg, eb_next;
    logic            out_pv_reg, out_pv_next, out_done_reg, out_done_next;
    logic [OutTriWidth-1:0] out_l_reg, out_l_next, out_e_reg, out_e_next;

    // Shared memory port controls.
    logic            rd_en;
    logic [AW:0]     rd_addr_a, rd_addr_b;
    logic            wr_en;
    logic            wr_to_b;
    logic [AW:0]     wr_addr;
    edge_t           wr_data;

    logic [AW:0]     n_edges;
    logic [VERTEX_BITS-1:0] ea, eb;
    edge_t           ld_edge;

    assign n_edges = (AW+1)'(3) * (AW+1)'(tri_cnt_reg);

    always_comb
    begin
        unique case (ld_idx_reg)
            2'd0:    begin ea = v0_reg; eb = v1_reg; end
            2'd1:    begin ea = v1_reg; eb = v2_reg; end
            default: begin ea = v2_reg; eb = v0_reg; end
        endcase
        ld_edge = (ea < eb) ? {ea, eb, tri_cnt_reg} : {eb, ea, tri_cnt_reg};
    end

    function automatic logic le(edge_t x, edge_t y);
        le = (x <= y);
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_RESP);
    assign rsp.later_triangle   = out_l_reg;
    assign rsp.earlier_triangle = out_e_reg;
    assign rsp.pair_valid       = out_pv_reg;
    assign rsp.all_done         = out_done_reg;
    assign rsp.overflowed       = ovf_reg;

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        tri_cnt_next = tri_cnt_reg;
        scan_next    = scan_reg;
        sorted_next  = sorted_reg;
        ovf_next     = ovf_reg;
        ld_idx_next  = ld_idx_reg;
        ld_last_next = ld_last_reg;
        width_next   = width_reg;
        i_next = i_reg; j_next = j_reg; mid_next = mid_reg; rgt_next = rgt_reg;
        k_next = k_reg;
        ea_next = ea_reg; eb_next = eb_reg;
        out_pv_next = out_pv_reg; out_done_next = out_done_reg;
        out_l_next = out_l_reg; out_e_next = out_e_reg;
        rd_en = 1'b0; rd_addr_a = '0; rd_addr_b = '0;
        wr_en = 1'b0; wr_to_b = 1'b0; wr_addr = '0; wr_data = ld_edge;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        if (sorted_reg)
                        begin
                            tri_cnt_next = '0;
                            ovf_next     = 1'b0;
                            sorted_next  = 1'b0;
                            sel_next     = 1'b0;
                        end
                        ld_last_next = req.last_triangle;
                        ld_idx_next  = 2'd0;
                        if (sorted_reg || tri_cnt_reg < TW'(MAX_TRIANGLES))
                            state_next = ST_LOAD;
                        else
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_PASS;
                        end
                        if (sorted_reg)
                            scan_next = AW'(1);
                    end
                    else
                    begin
                        out_pv_next = 1'b0; out_done_next = 1'b0;
                        out_l_next = '0; out_e_next = '0;
                        if (!sorted_reg)
                            state_next = ST_RESP;
                        else
                        begin
                            i_next     = (scan_reg == '0) ? (AW+1)'(1) : (AW+1)'(scan_reg);
                            state_next = ST_SCANR;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = n_edges + (AW+1)'(ld_idx_reg);
                ld_idx_next = ld_idx_reg + 2'd1;
                if (ld_idx_reg == 2'd2)
                begin
                    tri_cnt_next = tri_cnt_reg + TW'(1);
                    state_next   = ST_PASS;
                end
            end
            ST_PASS:
            begin
                // End of the load: back to idle, or start of the first merge pass.
                if (!ld_last_reg)
                    state_next = ST_IDLE;
                else
                begin
                    width_next = (AW+1)'(1);
                    k_next     = '0;
                    sel_next   = 1'b0;
                    state_next = ST_MRDA;
                    ld_last_next = 1'b0;
                    i_next = '0;
                    mid_next = (n_edges < (AW+1)'(1)) ? n_edges : (AW+1)'(1);
                    j_next = mid_next;
                    rgt_next = (n_edges < (AW+1)'(2)) ? n_edges : (AW+1)'(2);
                    if (n_edges <= (AW+1)'(1))
                    begin
                        sorted_next = 1'b1;
                        scan_next   = AW'(1);
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_MRDA:
            begin
                // Issue reads for both run heads.
                rd_en = 1'b1; rd_addr_a = i_reg; rd_addr_b = j_reg;
                state_next = ST_MRDB;
            end
            ST_MRDB:
            begin
                ea_next = rd_a_reg; eb_next = rd_b_reg;
                state_next = ST_MCMP;
            end
            ST_MCMP:
            begin
                wr_en   = 1'b1;
                wr_to_b = !sel_reg;
                wr_addr = k_reg;
                k_next  = k_reg + (AW+1)'(1);
                if (i_reg < mid_reg && (j_reg >= rgt_reg || le(ea_reg, eb_reg)))
                begin
                    wr_data = ea_reg; i_next = i_reg + (AW+1)'(1);
                end
                else
                begin
                    wr_data = eb_reg; j_next = j_reg + (AW+1)'(1);
                end
                state_next = ST_MRDA;
                if (k_reg + (AW+1)'(1) == rgt_reg)
                begin
                    if (rgt_reg >= n_edges)
                    begin
                        sel_next   = !sel_reg;
                        width_next = width_reg << 1;
                        k_next     = '0;
                        i_next     = '0;
                        mid_next = (n_edges < (width_reg << 1)) ? n_edges : (width_reg << 1);
                        j_next   = mid_next;
                        rgt_next = (n_edges < (width_reg << 2)) ? n_edges : (width_reg << 2);
                        if ((width_reg << 1) >= n_edges)
                        begin
                            sorted_next = 1'b1;
                            scan_next   = AW'(1);
                            state_next  = ST_IDLE;
                        end
                    end
                    else
                    begin
                        i_next   = rgt_reg;
                        mid_next = (n_edges < rgt_reg + width_reg) ? n_edges
                                                                    : rgt_reg + width_reg;
                        j_next   = mid_next;
                        rgt_next = (n_edges < rgt_reg + (width_reg << 1)) ? n_edges
                                                                    : rgt_reg + (width_reg << 1);
                    end
                end
            end
            ST_SCANR:
            begin
                if (i_reg >= n_edges)
                begin
                    scan_next     = (n_edges > (AW+1)'(1)) ? AW'(n_edges) : AW'(1);
                    out_done_next = 1'b1;
                    state_next    = ST_RESP;
                end
                else
                begin
                    rd_en = 1'b1; rd_addr_a = i_reg - (AW+1)'(1); rd_addr_b = i_reg;
                    state_next = ST_SCANC;
                end
            end
            ST_SCANC:
            begin
                if (rd_a_reg[EW-1:TW] == rd_b_reg[EW-1:TW]
                    && rd_a_reg[TW-1:0] != rd_b_reg[TW-1:0])
                begin
                    out_pv_next = 1'b1;
                    out_l_next  = OutTriWidth'(rd_b_reg[TW-1:0]);
                    out_e_next  = OutTriWidth'(rd_a_reg[TW-1:0]);
                    scan_next   = AW'(i_reg + (AW+1)'(1));
                    state_next  = ST_RESP;
                end
                else
                begin
                    i_next     = i_reg + (AW+1)'(1);
                    state_next = ST_SCANR;
                end
            end
            ST_RESP:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Two dual-read edge memories; sorting alternates between them.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= sel_reg ? mem_b[rd_addr_a[IW-1:0]] : mem_a[rd_addr_a[IW-1:0]];
            rd_b_reg <= sel_reg ? mem_b[rd_addr_b[IW-1:0]] : mem_a[rd_addr_b[IW-1:0]];
        end
        if (wr_en && wr_to_b)
            mem_b[wr_addr[IW-1:0]] <= wr_data;
        if (wr_en && !wr_to_b)
            mem_a[wr_addr[IW-1:0]] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid && req.action == ACT_LOAD)
        begin
            v0_reg <= VERTEX_BITS'(req.vertex_first);
            v1_reg <= VERTEX_BITS'(req.vertex_second);
            v2_reg <= VERTEX_BITS'(req.vertex_third);
        end
        width_reg <= width_next;
        i_reg <= i_next; j_reg <= j_next; mid_reg <= mid_next; rgt_reg <= rgt_next;
        k_reg <= k_next;
        ea_reg <= ea_next; eb_reg <= eb_next;
        out_l_reg <= out_l_next; out_e_reg <= out_e_next;
        ld_idx_reg <= ld_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sel_reg      <= 1'b0;
            tri_cnt_reg  <= '0;
            scan_reg     <= AW'(1);
            sorted_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            ld_last_reg  <= 1'b0;
            out_pv_reg   <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            tri_cnt_reg  <= tri_cnt_next;
            scan_reg     <= scan_next;
            sorted_reg   <= sorted_next;
            ovf_reg      <= ovf_next;
            ld_last_reg  <= ld_last_next;
            out_pv_reg   <= out_pv_next;
            out_done_reg <= out_done_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tri_cnt_reg <= TW'(MAX_TRIANGLES))
        else $error("triangle count above capacity");
    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.pair_valid && rsp.all_done))
        else $error("pair and done together");
    a_done_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.all_done) |-> sorted_reg)
        else $error("done before sort");
`endif
endmodule

>>> tb/tea_adjacency_checker.sv
module tea_adjacency_checker (
    input  logic        clk,
    input  logic        rst_n,
    tea_req_if          req,
    tea_rsp_if          rsp,
    output int unsigned errors,
    output int unsigned pending,
    output int unsigned pairs_seen,
    output int unsigned meshes_seen
);
    import tea_pkg::*;

    localparam int unsigned MaxTri = MaxTrianglesDefault;

    typedef struct packed {
        logic [VertexWidth-1:0] lo;
        logic [VertexWidth-1:0] hi;
        logic [15:0]            tri_id;
    } mesh_edge_t;

    typedef struct packed {
        logic [OutTriWidth-1:0] later_tri;
        logic [OutTriWidth-1:0] earlier_tri;
        logic                   pair_valid;
        logic                   all_done;
        logic                   overflowed;
    } adjacency_t;

    mesh_edge_t  edges [3*MaxTri];
    int unsigned tri_count;
    int unsigned scan_pos;
    bit          sorted;
    bit          ovf;
    adjacency_t  expected_q [$];

    function automatic bit edge_le(mesh_edge_t x, mesh_edge_t y);
        if (x.lo != y.lo) return x.lo < y.lo;
        if (x.hi != y.hi) return x.hi < y.hi;
        return x.tri_id <= y.tri_id;
    endfunction

    function automatic mesh_edge_t make_edge(logic [VertexWidth-1:0] a,
                                             logic [VertexWidth-1:0] b, int unsigned t);
        mesh_edge_t e;
        e.lo = (a < b) ? a : b;
        e.hi = (a < b) ? b : a;
        e.tri_id = t[15:0];
        return e;
    endfunction

    // Stable insertion sort; a stable order with the triangle tie-break matches
    // the merge sort exactly.
    task automatic sort_mesh(int unsigned n);
        mesh_edge_t  key;
        int          j;
        for (int i = 1; i < int'(n); i++)
        begin
            key = edges[i];
            j = i - 1;
            while (j >= 0 && !edge_le(edges[j], key))
            begin
                edges[j+1] = edges[j];
                j--;
            end
            edges[j+1] = key;
        end
    endtask

    task automatic handle_request();
        adjacency_t  r;
        int unsigned n;
        int unsigned i;
        if (req.action == ACT_LOAD)
        begin
            if (sorted)
            begin
                tri_count = 0;
                scan_pos  = 1;
                sorted    = 0;
                ovf       = 0;
            end
            if (tri_count < MaxTri)
            begin
                edges[3*tri_count]   = make_edge(req.vertex_first, req.vertex_second, tri_count);
                edges[3*tri_count+1] = make_edge(req.vertex_second, req.vertex_third, tri_count);
                edges[3*tri_count+2] = make_edge(req.vertex_third, req.vertex_first, tri_count);
                tri_count++;
            end
            else
                ovf = 1;
            if (req.last_triangle)
            begin
                sort_mesh(3*tri_count);
                sorted   = 1;
                scan_pos = 1;
                meshes_seen++;
            end
            return;
        end
        r = '0;
        r.overflowed = ovf;
        if (sorted)
        begin
            n = 3*tri_count;
            i = (scan_pos == 0) ? 1 : scan_pos;
            r.all_done = 1;
            while (i < n)
            begin
                if (edges[i].lo == edges[i-1].lo && edges[i].hi == edges[i-1].hi
                    && edges[i].tri_id != edges[i-1].tri_id)
                begin
                    r.later_tri   = edges[i].tri_id[OutTriWidth-1:0];
                    r.earlier_tri = edges[i-1].tri_id[OutTriWidth-1:0];
                    r.pair_valid  = 1;
                    r.all_done    = 0;
                    scan_pos = i + 1;
                    break;
                end
                i++;
            end
            if (r.all_done)
                scan_pos = (n > 1) ? n : 1;
        end
        expected_q = {expected_q, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        adjacency_t got;
        adjacency_t want;
        if (!rst_n)
        begin
            tri_count = 0;
            scan_pos  = 1;
            sorted    = 0;
            ovf       = 0;
            errors    = 0;
            pairs_seen = 0;
            meshes_seen = 0;
            expected_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.later_triangle, rsp.earlier_triangle, rsp.pair_valid,
                        rsp.all_done, rsp.overflowed};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected response %h", $realtime, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.pair_valid) pairs_seen++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch (exp/act) later %0d/%0d earlier %0d/%0d",
                                      " pair %b/%b done %b/%b ovf %b/%b"},
                                $realtime, want.later_tri, got.later_tri, want.earlier_tri,
                                got.earlier_tri, want.pair_valid, got.pair_valid,
                                want.all_done, got.all_done, want.overflowed, got.overflowed);
                    end
                end
            end
            if (req.valid && req.ready)
                handle_request();
        end
        pending = expected_q.size();
    end
endmodule

>>> tb/triangle_edge_adjacency_test.sv
module triangle_edge_adjacency_test;
    import tea_pkg::*;

    localparam int unsigned StallLimit = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tea_req_if req ();
    tea_rsp_if rsp ();

    int unsigned errors, pending, pairs_seen, meshes_seen;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned requests_sent = 0;

    always #4 clk = ~clk;

    triangle_edge_adjacency dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    tea_adjacency_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .errors(errors),
        .pending(pending), .pairs_seen(pairs_seen), .meshes_seen(meshes_seen)
    );

    initial
    begin
        req.valid = 1'b0;
        req.action = ACT_LOAD;
        req.vertex_first = '0;
        req.vertex_second = '0;
        req.vertex_third = '0;
        req.last_triangle = 1'b0;
        rsp.ready = 1'b0;
    end

    // The receiver stalls at random with the current phase's probability.
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

    // The watchdog ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit)
        begin
            $display("watchdog: no progress for %0d cycles", StallLimit);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one request, with a random idle gap before it, and hold it until taken.
    // Valid stays high after the accepting edge so that requests can follow back to back.
    task automatic send_request(action_t act, logic [15:0] a, logic [15:0] b,
                                logic [15:0] c, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.vertex_first <= a;
        req.vertex_second <= b;
        req.vertex_third <= c;
        req.last_triangle <= last;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic fetch_pair();
        send_request(ACT_FETCH, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // A test mesh: triangles over a small vertex pool so that
    // edges are shared, with some random and degenerate triangles mixed in, then fetches.
    task automatic build_mesh(int unsigned tris, int unsigned extra_fetches);
        logic [15:0] base;
        logic [15:0] v0, v1, v2;
        base = 16'($urandom);
        for (int unsigned t = 0; t < tris; t++)
        begin
            case ($urandom_range(9))
                0:       begin v0 = 16'($urandom); v1 = 16'($urandom); v2 = 16'($urandom); end
                1:       begin v0 = base + 16'(t); v1 = v0; v2 = base + 16'(t + 1); end
                default: begin
                    v0 = base + 16'($urandom_range(tris + 2));
                    v1 = base + 16'($urandom_range(tris + 2));
                    v2 = base + 16'(t + 2);
                end
            endcase
            send_request(ACT_LOAD, v0, v1, v2, t == tris - 1);
        end
        repeat (tris * 2 + extra_fetches)
            fetch_pair();
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fetch before any mesh, extreme vertices, three faces of a tetrahedron,
        // degenerate triangles, and fetches past the end.
        fetch_pair();
        send_request(ACT_LOAD, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        fetch_pair();
        send_request(ACT_LOAD, 16'h0000, 16'hFFFF, 16'h5555, 1'b0);
        send_request(ACT_LOAD, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
        send_request(ACT_LOAD, 16'h0000, 16'hAAAA, 16'h5555, 1'b1);
        repeat (9) fetch_pair();
        send_request(ACT_LOAD, 16'h0007, 16'h0007, 16'h0007, 1'b0);
        send_request(ACT_LOAD, 16'h0007, 16'h0007, 16'h0007, 1'b1);
        repeat (3) fetch_pair();
        send_request(ACT_LOAD, 16'h1234, 16'h1234, 16'h4321, 1'b1);
        repeat (2) fetch_pair();
        wait_drained();

        // Random meshes across phases of sender idling and receiver stalls.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3:       begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            repeat (6)
                build_mesh($urandom_range(1, 8), $urandom_range(0, 3));
            wait_drained();
        end

        $display("covered %0d requests over %0d meshes, %0d adjacency pairs returned",
                 requests_sent, meshes_seen, pairs_seen);
        $display("including sender idle and receiver stall phases and degenerate triangles");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> triangle_edge_adjacency.f
design/tea_pkg.sv
design/tea_if.sv
design/triangle_edge_adjacency.sv
tb/tea_adjacency_checker.sv
tb/triangle_edge_adjacency_test.sv
